// ===== hw/rtl/hws_pkg.sv =====
// hws_pkg: shared widths, codes and state types for the hysteretic wheel steering block.
// No dependencies; used by every module under hw/rtl.
package hws_pkg;

	localparam int ANGLE_W    = 15;
	localparam int LEN_W      = 16;
	localparam int THR_W      = 14;
	localparam int SPEED_W    = 18;
	localparam int PHASE_W    = 16;
	localparam int PROD_W     = LEN_W + ANGLE_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MUL_STEPS  = ANGLE_W;
	localparam int DIV_STEPS  = PROD_W;

	typedef enum logic [1:0] {
		MODE_STRAIGHT = 2'd0,
		MODE_SOFT     = 2'd1,
		MODE_HARD     = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HARD_THR     = 3'd0,
		REG_SOFT_THR     = 3'd1,
		REG_STRAIGHT_THR = 3'd2,
		REG_MAX_SPEED    = 3'd3,
		REG_PERIOD       = 3'd4,
		REG_PASSIVE      = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

// ===== hw/rtl/hws_serial_mul.sv =====
// hws_serial_mul: shift-add multiplier, one multiplier bit per cycle.
// Depends on hws_pkg for operand widths and step count.
module hws_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hws_pkg::LEN_W-1:0]   mcand,
	input  logic [hws_pkg::ANGLE_W-1:0] mplier,
	output logic                        done,
	output logic [hws_pkg::PROD_W-1:0]  product
);

	localparam int CNT_W = $clog2(hws_pkg::MUL_STEPS);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [hws_pkg::PROD_W-1:0]  acc_q;
	logic [hws_pkg::PROD_W-1:0]  mcand_q;
	logic [hws_pkg::ANGLE_W-1:0] mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(hws_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= hws_pkg::PROD_W'(mcand);
			mplier_q <= mplier;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[hws_pkg::PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[hws_pkg::ANGLE_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== hw/rtl/hws_serial_div.sv =====
// hws_serial_div: restoring divider, one quotient bit per cycle.
// Depends on hws_pkg for operand widths and step count.
module hws_serial_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hws_pkg::PROD_W-1:0] dividend,
	input  logic [hws_pkg::THR_W-1:0]  divisor,
	output logic                       done,
	output logic [hws_pkg::PROD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(hws_pkg::DIV_STEPS);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [hws_pkg::PROD_W-1:0] quo_q;
	logic [hws_pkg::THR_W-1:0]  rem_q;
	logic [hws_pkg::THR_W-1:0]  dsr_q;
	logic [hws_pkg::THR_W:0]    trial;
	logic [hws_pkg::THR_W:0]    diff;
	logic                       fits;

	assign trial = {rem_q, quo_q[hws_pkg::PROD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(hws_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[hws_pkg::THR_W-1:0] : trial[hws_pkg::THR_W-1:0];
			quo_q <= {quo_q[hws_pkg::PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/hysteretic_wheel_steering.sv =====
// hysteretic_wheel_steering: top level; mode hysteresis, broadcast phase, wheel speeds.
// Depends on hws_pkg, hws_serial_mul and hws_serial_div.
//
// One word in, one word out. A tick that ends in straight or hard mode, or in soft mode
// with a zero hard threshold, skips the arithmetic and goes straight to the output stage.
// A soft-mode tick runs the offset base*|angle|/hard_threshold through a bit-serial
// multiplier and a restoring divider before the output stage. Input is taken only
// while no tick is in work; a finished word sits in the output register, so the next input
// can be accepted while it waits. Configuration writes are always ready and take effect at
// once; write only while idle.
module hysteretic_wheel_steering (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hws_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hws_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [hws_pkg::ANGLE_W-1:0] heading_angle,
	input  logic [hws_pkg::LEN_W-1:0]         heading_length,
	input  logic                              committed,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [hws_pkg::SPEED_W-1:0] left_speed,
	output logic signed [hws_pkg::SPEED_W-1:0] right_speed,
	output logic [1:0]                        turn_mode,
	output logic                              send_opinion,
	output logic                              send_uncommitted
);

	localparam int AW = hws_pkg::ANGLE_W;
	localparam int LW = hws_pkg::LEN_W;
	localparam int TW = hws_pkg::THR_W;
	localparam int SW = hws_pkg::SPEED_W;
	localparam int PW = hws_pkg::PHASE_W;

	logic [TW-1:0] hard_thr_q, soft_thr_q, straight_thr_q;
	logic [LW-1:0] max_speed_q;
	logic [PW-1:0] period_q;
	logic          passive_q;

	hws_pkg::state_t state_q, state_d;
	hws_pkg::mode_t  mode_q, mode_d;
	logic [PW-1:0]   phase_q;

	logic [LW-1:0] base_q;
	logic [LW-1:0] d_q;
	logic          pos_q, send_q, unc_q;

	logic          out_valid_q;
	logic [SW-1:0] left_q, right_q;
	logic [1:0]    mode_out_q;
	logic          send_out_q, unc_out_q;

	logic          in_acc, use_div, mul_start, mul_done, div_done, out_load;
	logic [AW:0]   neg_angle;
	logic [AW-1:0] mag;
	logic [LW-1:0] base;
	logic [PW:0]   phase_inc;
	logic          due;
	logic [AW-1:0] hard_x, soft_x, straight_x;
	logic [hws_pkg::PROD_W-1:0] product, quotient;
	logic [SW-1:0] s1, s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_thr_q     <= TW'(3574);
			soft_thr_q     <= TW'(715);
			straight_thr_q <= TW'(357);
			max_speed_q    <= LW'(2560);
			period_q       <= PW'(10);
			passive_q      <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hws_pkg::REG_HARD_THR:     hard_thr_q     <= cfg_data[TW-1:0];
				hws_pkg::REG_SOFT_THR:     soft_thr_q     <= cfg_data[TW-1:0];
				hws_pkg::REG_STRAIGHT_THR: straight_thr_q <= cfg_data[TW-1:0];
				hws_pkg::REG_MAX_SPEED:    max_speed_q    <= cfg_data[LW-1:0];
				hws_pkg::REG_PERIOD:       period_q       <= cfg_data[PW-1:0];
				hws_pkg::REG_PASSIVE:      passive_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// magnitude, base speed, phase and mode hysteresis for the word at the input
	assign neg_angle  = -{heading_angle[AW-1], heading_angle};
	assign mag        = heading_angle[AW-1] ? neg_angle[AW-1:0] : heading_angle;
	assign base       = (heading_length < max_speed_q) ? heading_length : max_speed_q;
	assign phase_inc  = {1'b0, phase_q} + 1'b1;
	assign due        = phase_inc >= {1'b0, period_q};
	assign hard_x     = {1'b0, hard_thr_q};
	assign soft_x     = {1'b0, soft_thr_q};
	assign straight_x = {1'b0, straight_thr_q};

	always_comb begin
		mode_d = mode_q;
		if (mode_d == hws_pkg::MODE_HARD && mag <= soft_x)
			mode_d = hws_pkg::MODE_SOFT;
		if (mode_d == hws_pkg::MODE_SOFT) begin
			priority if (mag > hard_x)
				mode_d = hws_pkg::MODE_HARD;
			else if (mag <= straight_x)
				mode_d = hws_pkg::MODE_STRAIGHT;
			else
				mode_d = hws_pkg::MODE_SOFT;
		end
		if (mode_d == hws_pkg::MODE_STRAIGHT) begin
			priority if (mag > hard_x)
				mode_d = hws_pkg::MODE_HARD;
			else if (mag > straight_x)
				mode_d = hws_pkg::MODE_SOFT;
			else
				mode_d = hws_pkg::MODE_STRAIGHT;
		end
	end

	assign in_acc  = in_valid && in_ready;
	assign use_div = (mode_d == hws_pkg::MODE_SOFT) && (hard_thr_q != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hws_pkg::ST_IDLE: if (in_valid) state_d = use_div ? hws_pkg::ST_MUL : hws_pkg::ST_FIN;
			hws_pkg::ST_MUL:  if (mul_done) state_d = hws_pkg::ST_DIV;
			hws_pkg::ST_DIV:  if (div_done) state_d = hws_pkg::ST_FIN;
			hws_pkg::ST_FIN:  if (!out_valid_q || out_ready) state_d = hws_pkg::ST_IDLE;
			default:          state_d = hws_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == hws_pkg::ST_IDLE);
		mul_start = in_acc && use_div;
		out_load  = (state_q == hws_pkg::ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hws_pkg::ST_IDLE;
			mode_q      <= hws_pkg::MODE_STRAIGHT;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				mode_q  <= mode_d;
				phase_q <= due ? '0 : phase_inc[PW-1:0];
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	hws_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (base),
		.mplier  (mag),
		.done    (mul_done),
		.product (product)
	);

	hws_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_done),
		.dividend (product),
		.divisor  (hard_thr_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			base_q <= base;
			d_q    <= '0;
			pos_q  <= !heading_angle[AW-1] && (heading_angle != '0);
			send_q <= due && committed &&
				((mode_d != hws_pkg::MODE_HARD) || passive_q);
			unc_q  <= due && committed && passive_q && (mode_d == hws_pkg::MODE_HARD);
		end else if (div_done) begin
			d_q <= (quotient > hws_pkg::PROD_W'(base_q)) ? base_q : quotient[LW-1:0];
		end
	end

	always_comb begin
		if (mode_q == hws_pkg::MODE_HARD) begin
			s1 = -{2'b00, max_speed_q};
			s2 = {2'b00, max_speed_q};
		end else begin
			s1 = {2'b00, base_q} - {2'b00, d_q};
			s2 = {2'b00, base_q} + {2'b00, d_q};
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q     <= pos_q ? s1 : s2;
			right_q    <= pos_q ? s2 : s1;
			mode_out_q <= mode_q;
			send_out_q <= send_q;
			unc_out_q  <= unc_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign left_speed       = left_q;
	assign right_speed      = right_q;
	assign turn_mode        = mode_out_q;
	assign send_opinion     = send_out_q;
	assign send_uncommitted = unc_out_q;

endmodule

// ===== hw/rtl/hws_checker.sv =====
// hws_checker: port-level assertions for hysteretic_wheel_steering, plus its bind.
// Depends on hws_pkg; sees the top level's ports only.
module hws_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [hws_pkg::SPEED_W-1:0] left_speed,
	input logic signed [hws_pkg::SPEED_W-1:0] right_speed,
	input logic [1:0]                         turn_mode,
	input logic                               send_opinion,
	input logic                               send_uncommitted
);

	logic [hws_pkg::SPEED_W:0] speed_sum;

	assign speed_sum = {left_speed[hws_pkg::SPEED_W-1], left_speed} +
		{right_speed[hws_pkg::SPEED_W-1], right_speed};

	a_unc_needs_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_uncommitted |-> send_opinion)
		else $error("uncommitted flag without broadcast");

	a_unc_only_hard: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_uncommitted |-> turn_mode == hws_pkg::MODE_HARD)
		else $error("uncommitted broadcast outside hard mode");

	a_hard_opposite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && turn_mode == hws_pkg::MODE_HARD |-> speed_sum == '0)
		else $error("hard turn wheels not opposite");

	a_straight_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && turn_mode == hws_pkg::MODE_STRAIGHT |-> left_speed == right_speed)
		else $error("straight mode wheels differ");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_speed) && $stable(right_speed))
		else $error("stalled output word changed");

endmodule

bind hysteretic_wheel_steering hws_checker u_hws_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.left_speed       (left_speed),
	.right_speed      (right_speed),
	.turn_mode        (turn_mode),
	.send_opinion     (send_opinion),
	.send_uncommitted (send_uncommitted)
);
